// File: design/xor_checked_frame_receiver_assert.svh
// Assertion macros used by the frame receiver checker
`ifndef XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define XCFR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define XCFR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

// File: design/xcfr_pkg.sv
// Shared constants and controller/datapath interface types of the frame receiver
`default_nettype none

package xcfr_pkg;

   localparam int MAX_PAYLOAD_DEF = 64;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int POS_W       = 6;
   localparam int FILL_W      = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h55;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 1'b1;

   typedef struct packed {
      logic take_type;
      logic take_len_hi;
      logic take_len_lo;
      logic take_data;
      logic start_emit;
      logic issue_read;
      logic load_out;
   } xcfr_cmd_type;

   typedef struct packed {
      logic first_hit;
      logic second_hit;
      logic len_zero;
      logic len_over;
      logic fill_done;
      logic check_hit;
      logic frame_empty;
      logic emit_last;
      logic out_free;
   } xcfr_stat_type;

endpackage

`default_nettype wire

// File: design/xcfr_ctrl.sv
// Parse and emit sequencer of the frame receiver
`default_nettype none

module xcfr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire xcfr_pkg::xcfr_stat_type stat,
   output xcfr_pkg::xcfr_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_HUNT0,
      ST_HUNT1,
      ST_TYPE,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DATA,
      ST_CHECK,
      ST_EMIT_READ,
      ST_EMIT_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff != ST_EMIT_READ) && (state_ff != ST_EMIT_LOAD);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT0: begin
            if (accept && stat.first_hit) begin
               state_in = ST_HUNT1;
            end
         end
         ST_HUNT1: begin
            if (accept) begin
               state_in = stat.second_hit ? ST_TYPE : ST_HUNT0;
            end
         end
         ST_TYPE: begin
            if (accept) begin
               cmd.take_type = 1'b1;
               state_in      = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            if (accept) begin
               cmd.take_len_hi = 1'b1;
               state_in        = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (accept) begin
               cmd.take_len_lo = 1'b1;
               if (stat.len_zero) begin
                  state_in = ST_CHECK;
               end else if (stat.len_over) begin
                  state_in = ST_HUNT0;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.take_data = 1'b1;
               if (stat.fill_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               if (stat.check_hit) begin
                  cmd.start_emit = 1'b1;
                  state_in       = stat.frame_empty ? ST_EMIT_LOAD : ST_EMIT_READ;
               end else begin
                  state_in = ST_HUNT0;
               end
            end
         end
         ST_EMIT_READ: begin
            cmd.issue_read = 1'b1;
            state_in       = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = stat.emit_last ? ST_HUNT0 : ST_EMIT_READ;
            end
         end
         default: begin
            state_in = ST_HUNT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/xcfr_dpath.sv
// Datapath of the frame receiver: header capture, checksum, payload store, output register
`default_nettype none

module xcfr_dpath #(
   parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [xcfr_pkg::BYTE_W-1:0]         req_rx_byte,
   input  wire logic                                csr_wr_en,
   input  wire logic [xcfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [xcfr_pkg::BYTE_W-1:0]         csr_wdata,
   input  wire xcfr_pkg::xcfr_cmd_type              cmd,
   output xcfr_pkg::xcfr_stat_type                  stat,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [xcfr_pkg::BYTE_W-1:0]              rsp_frame_type,
   output logic [xcfr_pkg::LEN_W-1:0]               rsp_frame_length,
   output logic                                     rsp_data_valid,
   output logic [xcfr_pkg::BYTE_W-1:0]              rsp_payload_byte,
   output logic [xcfr_pkg::POS_W-1:0]               rsp_byte_position,
   output logic                                     rsp_last_of_frame
);

   localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [xcfr_pkg::BYTE_W-1:0] MaxLen = xcfr_pkg::BYTE_W'(MAX_PAYLOAD);

   logic [xcfr_pkg::BYTE_W-1:0] start_first_ff, start_first_in;
   logic [xcfr_pkg::BYTE_W-1:0] start_second_ff, start_second_in;
   logic [xcfr_pkg::BYTE_W-1:0] type_ff, type_in;
   logic [xcfr_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic [xcfr_pkg::BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [xcfr_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [xcfr_pkg::FILL_W-1:0] fill_ff, fill_in, fill_next;
   logic [xcfr_pkg::POS_W-1:0]  emit_ff, emit_in;
   logic [xcfr_pkg::LEN_W-1:0]  emit_next;
   logic [xcfr_pkg::BYTE_W-1:0] rd_data_ff;

   logic                        out_valid_ff, out_valid_in;
   logic [xcfr_pkg::BYTE_W-1:0] out_type_ff, out_type_in;
   logic [xcfr_pkg::LEN_W-1:0]  out_len_ff, out_len_in;
   logic                        out_dv_ff, out_dv_in;
   logic [xcfr_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic [xcfr_pkg::POS_W-1:0]  out_pos_ff, out_pos_in;
   logic                        out_last_ff, out_last_in;

   logic [xcfr_pkg::BYTE_W-1:0] store [MAX_PAYLOAD];

   assign fill_next = fill_ff + xcfr_pkg::FILL_W'(1);
   assign emit_next = xcfr_pkg::LEN_W'(emit_ff) + xcfr_pkg::LEN_W'(1);

   always_comb begin
      stat.first_hit   = (req_rx_byte == start_first_ff);
      stat.second_hit  = (req_rx_byte == start_second_ff);
      stat.len_zero    = (len_hi_ff == '0) && (req_rx_byte == '0);
      stat.len_over    = (len_hi_ff != '0) || (req_rx_byte > MaxLen);
      stat.fill_done   = (fill_next >= len_ff);
      stat.check_hit   = (req_rx_byte == xor_ff);
      stat.frame_empty = (len_ff == '0);
      stat.emit_last   = (len_ff == '0) || (emit_next == len_ff);
      stat.out_free    = !out_valid_ff || rsp_ready;
   end

   // register writes
   always_comb begin
      start_first_in  = start_first_ff;
      start_second_in = start_second_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            xcfr_pkg::CSR_START_FIRST:  start_first_in  = csr_wdata;
            xcfr_pkg::CSR_START_SECOND: start_second_in = csr_wdata;
            default: begin
               start_first_in = start_first_ff;
            end
         endcase
      end
   end

   always_comb begin
      type_in   = cmd.take_type ? req_rx_byte : type_ff;
      len_hi_in = cmd.take_len_hi ? req_rx_byte : len_hi_ff;
      len_in    = cmd.take_len_lo ? req_rx_byte[xcfr_pkg::LEN_W-1:0] : len_ff;

      if (cmd.take_type) begin
         xor_in = req_rx_byte;
      end else if (cmd.take_len_hi || cmd.take_len_lo || cmd.take_data) begin
         xor_in = xor_ff ^ req_rx_byte;
      end else begin
         xor_in = xor_ff;
      end

      if (cmd.take_len_lo) begin
         fill_in = '0;
      end else if (cmd.take_data) begin
         fill_in = fill_next;
      end else begin
         fill_in = fill_ff;
      end

      if (cmd.start_emit) begin
         emit_in = '0;
      end else if (cmd.load_out) begin
         emit_in = emit_next[xcfr_pkg::POS_W-1:0];
      end else begin
         emit_in = emit_ff;
      end
   end

   always_comb begin
      out_type_in = out_type_ff;
      out_len_in  = out_len_ff;
      out_dv_in   = out_dv_ff;
      out_byte_in = out_byte_ff;
      out_pos_in  = out_pos_ff;
      out_last_in = out_last_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_type_in  = type_ff;
         out_len_in   = len_ff;
         out_dv_in    = !stat.frame_empty;
         out_byte_in  = stat.frame_empty ? '0 : rd_data_ff;
         out_pos_in   = emit_ff;
         out_last_in  = stat.emit_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff  <= xcfr_pkg::START_FIRST_RST;
         start_second_ff <= xcfr_pkg::START_SECOND_RST;
         fill_ff         <= '0;
         emit_ff         <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         start_first_ff  <= start_first_in;
         start_second_ff <= start_second_in;
         fill_ff         <= fill_in;
         emit_ff         <= emit_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      xor_ff      <= xor_in;
      len_hi_ff   <= len_hi_in;
      len_ff      <= len_in;
      out_type_ff <= out_type_in;
      out_len_ff  <= out_len_in;
      out_dv_ff   <= out_dv_in;
      out_byte_ff <= out_byte_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
   end

   // payload store: write on each payload byte, registered read while emitting
   always_ff @(posedge clock) begin
      if (cmd.take_data) begin
         store[fill_ff[AddrW-1:0]] <= req_rx_byte;
      end
      if (cmd.issue_read) begin
         rd_data_ff <= store[emit_ff[AddrW-1:0]];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_type    = out_type_ff;
   assign rsp_frame_length  = out_len_ff;
   assign rsp_data_valid    = out_dv_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

`default_nettype wire

// File: design/xor_checked_frame_receiver.sv
// Length-prefixed frame receiver with XOR check byte: top level
//
// The req channel takes one received link byte per request (req_rx_byte).
// Frames are: two start bytes, type, length high, length low, payload,
// check byte (XOR of type, both length bytes and payload). Start byte values
// come from csr registers 0 and 1 (reset 0xAA and 0x55); the user must write
// them only while idle, which the block does not enforce. While parsing, a
// request is taken every cycle. A frame whose check byte matches is played out
// on the rsp channel, one response per payload byte with position, length, type
// and a last mark; an empty frame gives a single response with rsp_data_valid
// low. Oversized or failed frames give nothing.
// After the check byte is taken, each response goes through a registered
// payload store read, then an output register load (an empty frame goes
// straight to the load); req_ready is low during playback, which lasts until
// the last response is loaded and is extended by any rsp stall.
// rsp_ready low holds the output register; the final response may wait there
// while parsing of the next frame goes on.
// Reset (synchronous) returns to hunting the first start byte, empties the
// output register and restores the start byte registers.
`default_nettype none

module xor_checked_frame_receiver #(
   parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [xcfr_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [xcfr_pkg::BYTE_W-1:0]           rsp_frame_type,
   output logic [xcfr_pkg::LEN_W-1:0]            rsp_frame_length,
   output logic                                  rsp_data_valid,
   output logic [xcfr_pkg::BYTE_W-1:0]           rsp_payload_byte,
   output logic [xcfr_pkg::POS_W-1:0]            rsp_byte_position,
   output logic                                  rsp_last_of_frame,
   input  wire logic                             csr_wr_en,
   input  wire logic [xcfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [xcfr_pkg::BYTE_W-1:0]      csr_wdata
);

   xcfr_pkg::xcfr_cmd_type  cmd;
   xcfr_pkg::xcfr_stat_type stat;

   xcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   xcfr_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

// File: design/xcfr_checker.sv
// Port-level checker of the frame receiver, bound to the top level
`default_nettype none

`include "xor_checked_frame_receiver_assert.svh"

module xcfr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [xcfr_pkg::BYTE_W-1:0]   rsp_frame_type,
   input wire logic [xcfr_pkg::LEN_W-1:0]    rsp_frame_length,
   input wire logic                          rsp_data_valid,
   input wire logic [xcfr_pkg::BYTE_W-1:0]   rsp_payload_byte,
   input wire logic [xcfr_pkg::POS_W-1:0]    rsp_byte_position,
   input wire logic                          rsp_last_of_frame
);

   logic [xcfr_pkg::LEN_W-1:0] pos_next;

   assign pos_next = xcfr_pkg::LEN_W'(rsp_byte_position) + xcfr_pkg::LEN_W'(1);

   `XCFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_type) && $stable(rsp_frame_length) && $stable(rsp_data_valid) && $stable(rsp_payload_byte) && $stable(rsp_byte_position) && $stable(rsp_last_of_frame))
   `XCFR_ASSERT_NOW(a_empty_shape, rsp_valid && !rsp_data_valid, rsp_last_of_frame && (rsp_byte_position == '0) && (rsp_payload_byte == '0) && (rsp_frame_length == '0))
   `XCFR_ASSERT_NOW(a_pos_in_frame, rsp_valid && rsp_data_valid, pos_next <= rsp_frame_length)
   `XCFR_ASSERT_NOW(a_last_at_end, rsp_valid && rsp_data_valid, rsp_last_of_frame == (pos_next == rsp_frame_length))

endmodule

bind xor_checked_frame_receiver xcfr_checker u_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for the XOR-checked frame receiver: byte stimulus, frame predictor, response checks
`timescale 1ns / 100ps

module tb_top;

   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [2:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      TAKE_TYPE,
      TAKE_LEN_HI,
      TAKE_LEN_LO,
      TAKE_DATA,
      TAKE_CHECK
   } parse_phase_type;

   typedef struct packed {
      logic [xcfr_pkg::BYTE_W-1:0] frame_type;
      logic [xcfr_pkg::LEN_W-1:0]  frame_length;
      logic                        data_valid;
      logic [xcfr_pkg::BYTE_W-1:0] payload_byte;
      logic [xcfr_pkg::POS_W-1:0]  byte_position;
      logic                        last_of_frame;
   } frame_beat_type;

   class frame_scoreboard;
      logic [xcfr_pkg::BYTE_W-1:0] start_first;
      logic [xcfr_pkg::BYTE_W-1:0] start_second;
      parse_phase_type             phase;
      logic [xcfr_pkg::BYTE_W-1:0] frame_kind;
      logic [15:0]                 frame_len;
      logic [xcfr_pkg::FILL_W-1:0] fill;
      logic [xcfr_pkg::BYTE_W-1:0] check_acc;
      logic [xcfr_pkg::BYTE_W-1:0] store [xcfr_pkg::MAX_PAYLOAD_DEF];
      frame_beat_type              beats_due [$];
      int                          errors;

      function new();
         start_first  = xcfr_pkg::START_FIRST_RST;
         start_second = xcfr_pkg::START_SECOND_RST;
         phase        = HUNT_FIRST;
         frame_kind   = '0;
         frame_len    = '0;
         fill         = '0;
         check_acc    = '0;
         errors       = 0;
      endfunction

      function void set_start_byte(logic [xcfr_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [xcfr_pkg::BYTE_W-1:0] value);
         if (idx == xcfr_pkg::CSR_START_FIRST)
            start_first = value;
         else if (idx == xcfr_pkg::CSR_START_SECOND)
            start_second = value;
      endfunction

      function void note_request(logic [xcfr_pkg::BYTE_W-1:0] b);
         frame_beat_type beat;
         int n;
         case (phase)
            HUNT_FIRST: begin
               if (b == start_first)
                  phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
               phase = (b == start_second) ? TAKE_TYPE : HUNT_FIRST;
            end
            TAKE_TYPE: begin
               frame_kind = b;
               check_acc  = b;
               phase      = TAKE_LEN_HI;
            end
            TAKE_LEN_HI: begin
               frame_len = {b, 8'h00};
               check_acc = check_acc ^ b;
               phase     = TAKE_LEN_LO;
            end
            TAKE_LEN_LO: begin
               frame_len[7:0] = b;
               check_acc      = check_acc ^ b;
               fill           = '0;
               if (frame_len == 0)
                  phase = TAKE_CHECK;
               else if (frame_len > xcfr_pkg::MAX_PAYLOAD_DEF)
                  phase = HUNT_FIRST;
               else
                  phase = TAKE_DATA;
            end
            TAKE_DATA: begin
               store[fill[xcfr_pkg::POS_W-1:0]] = b;
               check_acc = check_acc ^ b;
               fill      = fill + 1'b1;
               if (fill >= frame_len)
                  phase = TAKE_CHECK;
            end
            TAKE_CHECK: begin
               if (b == check_acc) begin
                  beat.frame_type   = frame_kind;
                  beat.frame_length = frame_len[xcfr_pkg::LEN_W-1:0];
                  if (frame_len == 0) begin
                     beat.data_valid    = 1'b0;
                     beat.payload_byte  = '0;
                     beat.byte_position = '0;
                     beat.last_of_frame = 1'b1;
                     beats_due.push_back(beat);
                  end else begin
                     for (n = 0; n < frame_len; n++) begin
                        beat.data_valid    = 1'b1;
                        beat.payload_byte  = store[n[xcfr_pkg::POS_W-1:0]];
                        beat.byte_position = n[xcfr_pkg::POS_W-1:0];
                        beat.last_of_frame = (n == frame_len - 1);
                        beats_due.push_back(beat);
                     end
                  end
               end
               phase = HUNT_FIRST;
            end
            default: phase = HUNT_FIRST;
         endcase
      endfunction

      function void compare_field(string name, logic [xcfr_pkg::BYTE_W-1:0] want,
                                  logic [xcfr_pkg::BYTE_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(frame_beat_type got);
         frame_beat_type want;
         if (beats_due.size() == 0) begin
            errors++;
            $display("%0t: response expected none, got %h", $time, got);
            return;
         end
         want = beats_due.pop_front();
         compare_field("frame_type", want.frame_type, got.frame_type);
         compare_field("frame_length", xcfr_pkg::BYTE_W'(want.frame_length),
                       xcfr_pkg::BYTE_W'(got.frame_length));
         compare_field("data_valid", xcfr_pkg::BYTE_W'(want.data_valid),
                       xcfr_pkg::BYTE_W'(got.data_valid));
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("byte_position", xcfr_pkg::BYTE_W'(want.byte_position),
                       xcfr_pkg::BYTE_W'(got.byte_position));
         compare_field("last_of_frame", xcfr_pkg::BYTE_W'(want.last_of_frame),
                       xcfr_pkg::BYTE_W'(got.last_of_frame));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [xcfr_pkg::BYTE_W-1:0]      req_rx_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [xcfr_pkg::BYTE_W-1:0]      rsp_frame_type;
   logic [xcfr_pkg::LEN_W-1:0]       rsp_frame_length;
   logic                             rsp_data_valid;
   logic [xcfr_pkg::BYTE_W-1:0]      rsp_payload_byte;
   logic [xcfr_pkg::POS_W-1:0]       rsp_byte_position;
   logic                             rsp_last_of_frame;
   logic                             csr_wr_en = 1'b0;
   logic [xcfr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [xcfr_pkg::BYTE_W-1:0]      csr_wdata = '0;

   frame_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;

   xor_checked_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_response({rsp_frame_type, rsp_frame_length, rsp_data_valid,
                            rsp_payload_byte, rsp_byte_position, rsp_last_of_frame});
   end

   task automatic send_byte(input logic [xcfr_pkg::BYTE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.beats_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_start_bytes(input logic [xcfr_pkg::BYTE_W-1:0] first,
                                  input logic [xcfr_pkg::BYTE_W-1:0] second);
      csr_wr_en <= 1'b1;
      csr_index <= xcfr_pkg::CSR_START_FIRST;
      csr_wdata <= first;
      @(negedge clock);
      csr_index <= xcfr_pkg::CSR_START_SECOND;
      csr_wdata <= second;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_start_byte(xcfr_pkg::CSR_START_FIRST, first);
      sb.set_start_byte(xcfr_pkg::CSR_START_SECOND, second);
   endtask

   // fixed_byte below zero gives a random payload
   task automatic send_frame(input logic [xcfr_pkg::BYTE_W-1:0] kind, input logic [15:0] len,
                             input int fixed_byte, input bit corrupt);
      logic [xcfr_pkg::BYTE_W-1:0] sum;
      logic [xcfr_pkg::BYTE_W-1:0] b;
      int i;
      send_byte(sb.start_first);
      send_byte(sb.start_second);
      sum = kind ^ len[15:8] ^ len[7:0];
      send_byte(kind);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len <= xcfr_pkg::MAX_PAYLOAD_DEF) begin
         for (i = 0; i < len; i++) begin
            b = (fixed_byte < 0) ? xcfr_pkg::BYTE_W'($urandom_range(255))
                                 : xcfr_pkg::BYTE_W'(fixed_byte);
            sum = sum ^ b;
            send_byte(b);
         end
         send_byte(corrupt ? sum ^ (8'h01 << $urandom_range(7)) : sum);
      end
   endtask

   task automatic random_traffic(input int budget);
      int first_count;
      int pick;
      int len;
      first_count = bytes_sent;
      while (bytes_sent - first_count < budget) begin
         pick = $urandom_range(99);
         len  = $urandom_range(6);
         if (pick < 70)
            send_frame(xcfr_pkg::BYTE_W'($urandom_range(255)), 16'(len), -1, 1'b0);
         else if (pick < 80)
            send_frame(xcfr_pkg::BYTE_W'($urandom_range(255)), 16'(len), -1, 1'b1);
         else if (pick < 87)
            send_frame(xcfr_pkg::BYTE_W'($urandom_range(255)),
                       16'($urandom_range(16'hFFFF, xcfr_pkg::MAX_PAYLOAD_DEF + 1)),
                       -1, 1'b0);
         else if (pick < 93) begin
            send_byte(sb.start_first);
            send_byte(xcfr_pkg::BYTE_W'($urandom_range(255)));
         end else
            send_byte(xcfr_pkg::BYTE_W'($urandom_range(255)));
         if ($urandom_range(19) == 0)
            wait_drained();
      end
   endtask

   task automatic run_phase(input logic [xcfr_pkg::BYTE_W-1:0] first,
                            input logic [xcfr_pkg::BYTE_W-1:0] second,
                            input int idle, input int stall, input int budget);
      wait_drained();
      set_start_bytes(first, second);
      idle_pct  = idle;
      stall_pct = stall;
      random_traffic(budget);
   endtask

   initial begin
      logic [xcfr_pkg::BYTE_W-1:0] same_start;
      sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_frame(8'h00, 16'd0, -1, 1'b0);
      send_frame(8'h11, 16'd3, -1, 1'b1);
      // a repeated first start byte drops the hunt back to the first start byte
      send_byte(sb.start_first);
      send_byte(sb.start_first);
      send_byte(sb.start_second);
      send_frame(8'h80, 16'd65, -1, 1'b0);
      send_frame(8'h7F, 16'h0140, -1, 1'b0);

      run_phase(8'h00, 8'hFF, 56, 0, 8);
      run_phase(8'hFF, 8'h00, 0, 56, 0);
      send_frame(xcfr_pkg::BYTE_W'($urandom_range(255)), 16'd64, -1, 1'b0);
      same_start = xcfr_pkg::BYTE_W'($urandom_range(255));
      run_phase(same_start, same_start, 32, 32, 8);
      wait_drained();

      if (sb.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/xcfr_pkg.sv
design/xcfr_ctrl.sv
design/xcfr_dpath.sv
design/xor_checked_frame_receiver.sv
design/xcfr_checker.sv
bench/tb_top.sv
